@@ hw/rtl/ca_pkg.sv @@
package ca_pkg;

	localparam int PROPOSAL_BITS = 32;
	localparam int NODE_BITS     = 8;
	localparam int VALUE_BITS    = 64;
	localparam int INSTANCE_BITS = 32;
	localparam int KIND_BITS     = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [KIND_BITS-1:0] {
		KIND_PREPARE      = 2'd0,
		KIND_ACCEPT       = 2'd1,
		KIND_PUBLISH      = 2'd2,
		KIND_NEW_INSTANCE = 2'd3
	} kind_t;

	// classified request as it sits in the queue
	typedef struct packed {
		kind_t                     kind;
		logic                      has_reply;
		logic [INSTANCE_BITS-1:0]  inst;
		logic [PROPOSAL_BITS-1:0]  num;
		logic [NODE_BITS-1:0]      node;
		logic [VALUE_BITS-1:0]     value;
	} cmd_t;

	typedef struct packed {
		logic [KIND_BITS-1:0]      reply_kind;
		logic [NODE_BITS-1:0]      reply_to;
		logic                      rejected;
		logic [PROPOSAL_BITS-1:0]  promised_num;
		logic [NODE_BITS-1:0]      promised_node;
		logic                      has_accepted;
		logic [PROPOSAL_BITS-1:0]  accepted_num;
		logic [VALUE_BITS-1:0]     prior_value;
		logic                      publish_ok;
	} reply_t;

	// queue status towards the front end (full) and the back end (empty)
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

@@ hw/rtl/ca_ifs.sv @@
interface ca_req_if;
	logic                               valid;
	logic                               ready;
	logic [ca_pkg::KIND_BITS-1:0]       kind;
	logic [ca_pkg::INSTANCE_BITS-1:0]   instance_num;
	logic [ca_pkg::PROPOSAL_BITS-1:0]   proposal_num;
	logic [ca_pkg::NODE_BITS-1:0]       proposer_node;
	logic [ca_pkg::VALUE_BITS-1:0]      proposed_value;

	modport source (
		output valid, kind, instance_num, proposal_num, proposer_node, proposed_value,
		input  ready
	);
	modport sink (
		input  valid, kind, instance_num, proposal_num, proposer_node, proposed_value,
		output ready
	);
endinterface

interface ca_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [ca_pkg::KIND_BITS-1:0]       reply_kind;
	logic [ca_pkg::NODE_BITS-1:0]       reply_to;
	logic                               rejected;
	logic [ca_pkg::PROPOSAL_BITS-1:0]   promised_num_out;
	logic [ca_pkg::NODE_BITS-1:0]       promised_node_out;
	logic                               has_accepted;
	logic [ca_pkg::PROPOSAL_BITS-1:0]   accepted_num_out;
	logic [ca_pkg::VALUE_BITS-1:0]      accepted_value_out;
	logic                               publish_ok;

	modport source (
		output valid, reply_kind, reply_to, rejected, promised_num_out, promised_node_out,
		       has_accepted, accepted_num_out, accepted_value_out, publish_ok,
		input  ready
	);
	modport sink (
		input  valid, reply_kind, reply_to, rejected, promised_num_out, promised_node_out,
		       has_accepted, accepted_num_out, accepted_value_out, publish_ok,
		output ready
	);
endinterface

@@ hw/rtl/consensus_acceptor.sv @@
// Single-decree Paxos acceptor. Each request beat (prepare, accept, publish check or
// new instance) is decoded by the front end and parked in a two-entry queue; the back
// end compares it against the promise, updates the acceptor state and loads the reply
// into an output register. One beat per cycle is sustained while replies are taken;
// a reply passes through a queue entry and then the output register. A new-instance
// beat gives no reply and is retired without waiting on the reply port. The request
// side only stalls when the queue is full, i.e. when replies back up.
module consensus_acceptor (
	input  logic   clk,
	input  logic   arst_n,
	ca_req_if.sink   req,
	ca_rsp_if.source rsp
);
	import ca_pkg::*;

	q_status_t  q_status;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;

	ca_front u_front (
		.req      (req),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	ca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	ca_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.rsp      (rsp)
	);
endmodule

@@ hw/rtl/ca_front.sv @@
module ca_front (
	ca_req_if.sink             req,
	input  ca_pkg::q_status_t  q_status,
	output logic               push,
	output ca_pkg::cmd_t       push_cmd
);
	import ca_pkg::*;

	kind_t kind;

	assign kind      = kind_t'(req.kind);
	assign req.ready = !q_status.full;
	assign push      = req.valid && !q_status.full;

	always_comb begin
		push_cmd.kind  = kind;
		push_cmd.inst  = req.instance_num;
		push_cmd.num   = req.proposal_num;
		push_cmd.node  = req.proposer_node;
		push_cmd.value = req.proposed_value;
		unique case (kind)
			KIND_PREPARE, KIND_ACCEPT, KIND_PUBLISH: push_cmd.has_reply = 1'b1;
			KIND_NEW_INSTANCE:                       push_cmd.has_reply = 1'b0;
			default:                                 push_cmd.has_reply = 1'b0;
		endcase
	end
endmodule

@@ hw/rtl/ca_queue.sv @@
module ca_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ca_pkg::cmd_t       push_cmd,
	input  logic               pop,
	output ca_pkg::cmd_t       head,
	output ca_pkg::q_status_t  status
);
	import ca_pkg::*;

	cmd_t                 entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;

	assign status.full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign head         = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
		end
	end
endmodule

@@ hw/rtl/ca_back.sv @@
module ca_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ca_pkg::cmd_t       head,
	input  ca_pkg::q_status_t  q_status,
	output logic               pop,
	ca_rsp_if.source           rsp
);
	import ca_pkg::*;

	logic [PROPOSAL_BITS-1:0]  promised_num_q;
	logic [NODE_BITS-1:0]      promised_node_q;
	logic [PROPOSAL_BITS-1:0]  accepted_num_q;
	logic [NODE_BITS-1:0]      accepted_node_q;
	logic [VALUE_BITS-1:0]     acc_value_q;
	logic [INSTANCE_BITS-1:0]  current_instance_q;

	reply_t  reply_q;
	reply_t  reply_d;
	logic    rsp_valid_q;
	logic    out_free;
	logic    above;
	logic    equal;
	logic    nothing_accepted;
	logic    take_promise;
	logic    take_accept;

	// output register frees up this cycle if empty or being drained
	assign out_free = !rsp_valid_q || rsp.ready;
	assign pop      = !q_status.empty && (!head.has_reply || out_free);

	// lexicographic (number, node) against the promise
	assign above = (head.num > promised_num_q) ||
	               ((head.num == promised_num_q) && (head.node > promised_node_q));
	assign equal = (head.num == promised_num_q) && (head.node == promised_node_q);
	assign nothing_accepted = (accepted_num_q == '0);

	always_comb begin
		reply_d            = '0;
		reply_d.reply_kind = head.kind;
		reply_d.reply_to   = head.node;
		take_promise       = 1'b0;
		take_accept        = 1'b0;
		unique case (head.kind)
			KIND_PREPARE: begin
				if (above) begin
					take_promise = 1'b1;
					if (!nothing_accepted) begin
						reply_d.has_accepted = 1'b1;
						reply_d.accepted_num = accepted_num_q;
						reply_d.prior_value  = acc_value_q;
					end
				end else begin
					reply_d.rejected      = 1'b1;
					reply_d.promised_num  = promised_num_q;
					reply_d.promised_node = promised_node_q;
				end
			end
			KIND_ACCEPT: begin
				if (above || equal) begin
					take_promise = 1'b1;
					take_accept  = 1'b1;
				end else begin
					reply_d.rejected     = 1'b1;
					reply_d.promised_num = promised_num_q;
				end
			end
			KIND_PUBLISH: begin
				reply_d.publish_ok = (head.inst == current_instance_q) && !nothing_accepted &&
				                     (accepted_num_q == head.num) &&
				                     (accepted_node_q == head.node);
			end
			KIND_NEW_INSTANCE: begin
				reply_d = '0;
			end
			default: begin
				reply_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			promised_num_q     <= '0;
			promised_node_q    <= '0;
			accepted_num_q     <= '0;
			accepted_node_q    <= '0;
			acc_value_q        <= '0;
			current_instance_q <= '0;
		end else if (pop) begin
			if (head.kind == KIND_NEW_INSTANCE) begin
				promised_num_q     <= '0;
				promised_node_q    <= '0;
				accepted_num_q     <= '0;
				accepted_node_q    <= '0;
				acc_value_q        <= '0;
				current_instance_q <= head.inst;
			end else begin
				if (take_promise) begin
					promised_num_q  <= head.num;
					promised_node_q <= head.node;
				end
				if (take_accept) begin
					accepted_num_q  <= head.num;
					accepted_node_q <= head.node;
					acc_value_q     <= head.value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			priority if (pop && head.has_reply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end else begin
				rsp_valid_q <= rsp_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.has_reply) begin
			reply_q <= reply_d;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.reply_kind         = reply_q.reply_kind;
	assign rsp.reply_to           = reply_q.reply_to;
	assign rsp.rejected           = reply_q.rejected;
	assign rsp.promised_num_out   = reply_q.promised_num;
	assign rsp.promised_node_out  = reply_q.promised_node;
	assign rsp.has_accepted       = reply_q.has_accepted;
	assign rsp.accepted_num_out   = reply_q.accepted_num;
	assign rsp.accepted_value_out = reply_q.prior_value;
	assign rsp.publish_ok         = reply_q.publish_ok;
endmodule
